// File: sv/iso_dtc_pkg.sv
// Shared types, state layout and character codes of the ISO 8601 datetime checker.
package iso_dtc_pkg;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_DASH  = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_COLON = 8'h3A;
    localparam logic [7:0] CH_DOT   = 8'h2E;
    localparam logic [7:0] CH_T     = 8'h54;
    localparam logic [7:0] CH_Z     = 8'h5A;

    localparam logic [4:0] POS_MAX  = 5'd31;

    localparam logic [1:0] FORM_NONE     = 2'd0;
    localparam logic [1:0] FORM_BASIC    = 2'd1;
    localparam logic [1:0] FORM_EXTENDED = 2'd2;

    // Step reached in the optional tail; PH_FIXED while in the fixed-length part.
    typedef enum logic [3:0] {
        PH_FIXED    = 4'd0,
        PH_SEC_END  = 4'd1,
        PH_BF1      = 4'd2,
        PH_BF2      = 4'd3,
        PH_BF3      = 4'd4,
        PH_FRAC_END = 4'd5,
        PH_TZ1      = 4'd6,
        PH_TZ2      = 4'd7,
        PH_TZ3      = 4'd8,
        PH_TZ4      = 4'd9,
        PH_TZ5      = 4'd10,
        PH_DONE     = 4'd11,
        PH_MIN_END  = 4'd12,
        PH_ES1      = 4'd13,
        PH_ES2      = 4'd14
    } phase_t;

    // The year is kept as its upper and lower two-digit halves.
    typedef struct packed {
        logic [4:0] pos;
        logic       basic_alive;
        logic       ext_alive;
        phase_t     phase;
        logic [6:0] year_hi;
        logic [6:0] year_lo;
        logic [6:0] month;
        logic [6:0] day;
        logic [6:0] hour;
        logic [6:0] minute;
        logic [6:0] second;
    } dtc_state_t;

    localparam dtc_state_t DTC_RESET = '{
        pos: 5'd0, basic_alive: 1'b1, ext_alive: 1'b1, phase: PH_FIXED,
        year_hi: 7'd0, year_lo: 7'd0, month: 7'd0, day: 7'd0,
        hour: 7'd0, minute: 7'd0, second: 7'd0
    };

    // Verdict of one step, from the step logic to the top level.
    typedef struct packed {
        logic accept;
        logic basic;
    } dtc_verdict_t;

    function automatic logic is_num(input logic [7:0] c);
        return (c >= CH_ZERO) && (c <= CH_NINE);
    endfunction

    // v * 10 + digit, kept to 7 bits
    function automatic logic [6:0] push_digit(input logic [6:0] v, input logic [7:0] c);
        logic [10:0] sum;
        sum = {1'b0, v, 3'b000} + {3'b000, v, 1'b0} + {3'b000, c - CH_ZERO};
        return sum[6:0];
    endfunction

endpackage

// File: sv/iso_dtc_step.sv
// Next-state and verdict logic for one character of the datetime checker.
module iso_dtc_step
    import iso_dtc_pkg::*;
(
    input  dtc_state_t   cur,
    input  logic [7:0]   ch,
    output dtc_state_t   nxt,
    output dtc_verdict_t verdict
);

    logic   dig;
    logic   sign;
    logic   match_b;
    logic   match_e;
    logic   b_ok;
    logic   e_ok;
    logic   ext;
    phase_t tail_nx;
    logic   leap;
    logic [4:0] lim;
    logic   date_ok;
    logic   time_ok;
    logic   end_phase;

    assign dig  = is_num(ch);
    assign sign = (ch == CH_PLUS) || (ch == CH_DASH);
    assign ext  = !cur.basic_alive;

    always_comb begin
        match_b = (cur.pos == 5'd8) ? (ch == CH_T) : dig;
        unique case (cur.pos)
            5'd4, 5'd7: match_e = (ch == CH_DASH);
            5'd10:      match_e = (ch == CH_T);
            5'd13:      match_e = (ch == CH_COLON);
            default:    match_e = dig;
        endcase
    end

    always_comb begin
        tail_nx = PH_FIXED;
        unique case (cur.phase)
            PH_SEC_END, PH_MIN_END, PH_FRAC_END: begin
                priority if (cur.phase == PH_SEC_END && ch == CH_DOT)
                    tail_nx = ext ? PH_FRAC_END : PH_BF1;
                else if (cur.phase == PH_MIN_END && ch == CH_COLON)
                    tail_nx = PH_ES1;
                else if (cur.phase == PH_FRAC_END && dig && ext)
                    tail_nx = PH_FRAC_END;
                else if (ch == CH_Z)
                    tail_nx = PH_DONE;
                else if (sign)
                    tail_nx = PH_TZ1;
                else
                    tail_nx = PH_FIXED;
            end
            PH_BF1:  tail_nx = dig ? PH_BF2 : PH_FIXED;
            PH_BF2:  tail_nx = dig ? PH_BF3 : PH_FIXED;
            PH_BF3:  tail_nx = dig ? PH_FRAC_END : PH_FIXED;
            PH_TZ1:  tail_nx = dig ? PH_TZ2 : PH_FIXED;
            PH_TZ2:  tail_nx = dig ? PH_TZ3 : PH_FIXED;
            PH_TZ3:  tail_nx = (ext ? (ch == CH_COLON) : dig) ? PH_TZ4 : PH_FIXED;
            PH_TZ4:  tail_nx = dig ? (ext ? PH_TZ5 : PH_DONE) : PH_FIXED;
            PH_TZ5:  tail_nx = dig ? PH_DONE : PH_FIXED;
            PH_ES1:  tail_nx = dig ? PH_ES2 : PH_FIXED;
            PH_ES2:  tail_nx = dig ? PH_SEC_END : PH_FIXED;
            default: tail_nx = PH_FIXED;
        endcase
    end

    always_comb begin
        nxt  = cur;
        b_ok = 1'b0;
        e_ok = 1'b0;
        if (cur.basic_alive || cur.ext_alive) begin
            if (cur.phase == PH_FIXED) begin
                b_ok = cur.basic_alive && (cur.pos <= 5'd14) && match_b;
                e_ok = cur.ext_alive && (cur.pos <= 5'd15) && match_e;
                nxt.basic_alive = b_ok;
                nxt.ext_alive   = e_ok;
                if (b_ok || e_ok) begin
                    if (dig) begin
                        priority if (cur.pos < 5'd2) begin
                            nxt.year_hi = push_digit(cur.year_hi, ch);
                        end else if (cur.pos < 5'd4) begin
                            nxt.year_lo = push_digit(cur.year_lo, ch);
                        end else if (b_ok) begin
                            unique case (cur.pos)
                                5'd4, 5'd5:   nxt.month  = push_digit(cur.month, ch);
                                5'd6, 5'd7:   nxt.day    = push_digit(cur.day, ch);
                                5'd9, 5'd10:  nxt.hour   = push_digit(cur.hour, ch);
                                5'd11, 5'd12: nxt.minute = push_digit(cur.minute, ch);
                                5'd13, 5'd14: nxt.second = push_digit(cur.second, ch);
                                default: ;
                            endcase
                        end else begin
                            unique case (cur.pos)
                                5'd5, 5'd6:   nxt.month  = push_digit(cur.month, ch);
                                5'd8, 5'd9:   nxt.day    = push_digit(cur.day, ch);
                                5'd11, 5'd12: nxt.hour   = push_digit(cur.hour, ch);
                                5'd14, 5'd15: nxt.minute = push_digit(cur.minute, ch);
                                default: ;
                            endcase
                        end
                    end
                    if (b_ok && cur.pos == 5'd14) nxt.phase = PH_SEC_END;
                    if (!b_ok && cur.pos == 5'd15) nxt.phase = PH_MIN_END;
                end
            end else begin
                // extended seconds arrive in the tail
                if ((cur.phase == PH_ES1 || cur.phase == PH_ES2) && dig)
                    nxt.second = push_digit(cur.second, ch);
                if (tail_nx == PH_FIXED) begin
                    nxt.basic_alive = 1'b0;
                    nxt.ext_alive   = 1'b0;
                end
                nxt.phase = tail_nx;
            end
        end
        nxt.pos = (cur.pos == POS_MAX) ? cur.pos : cur.pos + 5'd1;
    end

    // Gregorian leap year from the two halves of the year
    assign leap = (nxt.year_lo[1:0] == 2'b00) &&
                  ((nxt.year_lo != 7'd0) || (nxt.year_hi[1:0] == 2'b00));

    always_comb begin
        unique case (nxt.month)
            7'd2:                     lim = leap ? 5'd29 : 5'd28;
            7'd4, 7'd6, 7'd9, 7'd11:  lim = 5'd30;
            default:                  lim = 5'd31;
        endcase
    end

    assign date_ok = (nxt.month >= 7'd1) && (nxt.month <= 7'd12) &&
                     (nxt.day >= 7'd1) && (nxt.day <= {2'b00, lim});
    assign time_ok = (nxt.hour <= 7'd23) && (nxt.minute <= 7'd59) &&
                     (nxt.second <= 7'd59);
    assign end_phase = (nxt.phase == PH_SEC_END) || (nxt.phase == PH_FRAC_END) ||
                       (nxt.phase == PH_DONE) || (nxt.phase == PH_MIN_END);

    assign verdict.accept = (nxt.basic_alive || nxt.ext_alive) && end_phase &&
                            date_ok && time_ok;
    assign verdict.basic  = nxt.basic_alive;

endmodule

// File: sv/iso8601_datetime_checker_core.sv
// ISO 8601 datetime checker: character stream in, one verdict per string out.
//
// Characters enter on the s_ channel, one per item, with s_tlast on the final
// character of a string. The block takes one character per cycle while not
// stalled: each item is held in an input register, the next-state and verdict
// logic runs on it, and the string state is updated at the edge where the item
// leaves that register. The item with s_tlast set raises m_tvalid at that edge
// and returns the string state to its reset value, so the next string may
// follow at once. Input is stalled only while a finished result waits
// unaccepted at m_ and the character in the input register is itself a final
// character.
module iso8601_datetime_checker_core
    import iso_dtc_pkg::*;
(
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] ch
    input  logic       s_tlast,   // last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata    // [0] valid_res, [2:1] form, [7:3] zero
);

    logic         in_valid_reg;
    logic [7:0]   in_ch_reg;
    logic         in_last_reg;
    dtc_state_t   state_reg;
    dtc_state_t   step_nxt;
    dtc_verdict_t verdict;
    logic         out_valid_reg;
    logic         out_res_reg;
    logic [1:0]   out_form_reg;
    logic         advance;

    iso_dtc_step u_step (
        .cur     (state_reg),
        .ch      (in_ch_reg),
        .nxt     (step_nxt),
        .verdict (verdict)
    );

    // A non-final item never needs the result register.
    assign advance  = in_valid_reg && (!in_last_reg || !out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            state_reg     <= DTC_RESET;
        end else begin
            if (s_tready) in_valid_reg <= s_tvalid;
            if (advance) state_reg <= in_last_reg ? DTC_RESET : step_nxt;
            if (advance && in_last_reg) out_valid_reg <= 1'b1;
            else if (m_tready)          out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_ch_reg   <= s_tdata;
            in_last_reg <= s_tlast;
        end
        if (advance && in_last_reg) begin
            out_res_reg  <= verdict.accept;
            out_form_reg <= !verdict.accept ? FORM_NONE :
                            (verdict.basic ? FORM_BASIC : FORM_EXTENDED);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'b00000, out_form_reg, out_res_reg};

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(in_valid_reg && in_last_reg))
        else $error("result appeared without a final character");

    a_form_matches_res: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg |-> (out_res_reg == (out_form_reg != FORM_NONE)))
        else $error("form and verdict disagree");

    a_state_cleared: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_last_reg) |=> (state_reg == DTC_RESET))
        else $error("string state not cleared after final character");

    a_stall_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |-> (in_last_reg && out_valid_reg && !m_tready))
        else $error("input stalled without a waiting result");

endmodule

// File: tb/sv/tb_top.sv
// Self-checking testbench of the ISO 8601 datetime checker core.
module tb_top;
    import iso_dtc_pkg::*;

    localparam int CLK_HALF      = 6;
    localparam int RESET_CYCLES  = 12;
    localparam int RANDOM_CHARS  = 950;
    localparam int LIMIT_CYCLES  = 200000;
    localparam int STALL_AT      = 700;
    localparam int STALL_CYCLES  = 300;
    localparam int QUIET_FROM    = 900;
    localparam int QUIET_TO      = 1200;
    localparam int IDLE_PERCENT  = 18;
    localparam int SETTLE_CYCLES = 10;

    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         hold_for_drain;
    } char_item_t;

    typedef struct {
        logic       valid_res;
        logic [1:0] form;
    } verdict_t;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata = 8'h00;   // [7:0] ch
    logic       s_tlast = 1'b0;    // last
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] valid_res, [2:1] form, [7:3] zero

    char_item_t chars_pending[$];
    verdict_t   verdicts_due[$];
    logic [7:0] text_buf[$];
    int         sent_count = 0;
    int         err_count = 0;

    // string state of the checker as the testbench tracks it
    logic [4:0]  chk_pos;
    logic        chk_basic;
    logic        chk_ext;
    phase_t      chk_phase;
    logic [13:0] chk_year;
    logic [6:0]  chk_month;
    logic [6:0]  chk_day;
    logic [6:0]  chk_hour;
    logic [6:0]  chk_min;
    logic [6:0]  chk_sec;

    iso8601_datetime_checker_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial begin
        forever #(CLK_HALF) aclk = ~aclk;
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        err_count++;
    endtask

    function automatic bit char_is_num(input logic [7:0] c);
        return c >= CH_ZERO && c <= CH_NINE;
    endfunction

    // v * 10 + digit, wrapped to 7 bits
    function automatic logic [6:0] next7(input logic [6:0] v, input logic [7:0] c);
        return 7'(v * 7'd10 + 7'(c - CH_ZERO));
    endfunction

    task automatic clear_string_state();
        chk_pos   = '0;
        chk_basic = 1'b1;
        chk_ext   = 1'b1;
        chk_phase = PH_FIXED;
        chk_year  = '0;
        chk_month = '0;
        chk_day   = '0;
        chk_hour  = '0;
        chk_min   = '0;
        chk_sec   = '0;
    endtask

    function automatic bit date_in_range();
        int  top;
        bit  leap_year;
        leap_year = (chk_year % 4 == 0) && ((chk_year % 100 != 0) || (chk_year % 400 == 0));
        if (chk_month < 1 || chk_month > 12)
            return 1'b0;
        case (chk_month)
            7'd2:                     top = leap_year ? 29 : 28;
            7'd4, 7'd6, 7'd9, 7'd11:  top = 30;
            default:                  top = 31;
        endcase
        return chk_day >= 1 && chk_day <= top;
    endfunction

    // Fold one character into the tracked state; queue the verdict on a final character.
    task automatic advance_checker_model(input logic [7:0] c, input logic fin);
        logic [4:0] p;
        bit         d;
        bit         ext;
        bit         ext_match;
        bit         acc;
        phase_t     nx;
        verdict_t   v;
        p = chk_pos;
        d = char_is_num(c);
        if (chk_basic || chk_ext) begin
            if (chk_phase == PH_FIXED) begin
                if (chk_basic && (p > 14 || !((p == 8) ? (c == CH_T) : d)))
                    chk_basic = 1'b0;
                if (p == 4 || p == 7)
                    ext_match = (c == CH_DASH);
                else if (p == 10)
                    ext_match = (c == CH_T);
                else if (p == 13)
                    ext_match = (c == CH_COLON);
                else
                    ext_match = d;
                if (chk_ext && (p > 15 || !ext_match))
                    chk_ext = 1'b0;
                if (chk_basic || chk_ext) begin
                    if (d) begin
                        if (p < 4)
                            chk_year = 14'(chk_year * 14'd10 + 14'(c - CH_ZERO));
                        else if (chk_basic) begin
                            if (p < 6)       chk_month = next7(chk_month, c);
                            else if (p < 8)  chk_day   = next7(chk_day, c);
                            else if (p >= 9 && p < 11)  chk_hour = next7(chk_hour, c);
                            else if (p >= 11 && p < 13) chk_min  = next7(chk_min, c);
                            else if (p >= 13 && p < 15) chk_sec  = next7(chk_sec, c);
                        end else begin
                            if (p == 5 || p == 6)        chk_month = next7(chk_month, c);
                            else if (p == 8 || p == 9)   chk_day   = next7(chk_day, c);
                            else if (p == 11 || p == 12) chk_hour  = next7(chk_hour, c);
                            else if (p == 14 || p == 15) chk_min   = next7(chk_min, c);
                        end
                    end
                    if (chk_basic && p == 14)
                        chk_phase = PH_SEC_END;
                    if (!chk_basic && p == 15)
                        chk_phase = PH_MIN_END;
                end
            end else begin
                ext = !chk_basic;
                case (chk_phase)
                    PH_SEC_END, PH_MIN_END, PH_FRAC_END: begin
                        if (chk_phase == PH_SEC_END && c == CH_DOT)
                            nx = ext ? PH_FRAC_END : PH_BF1;
                        else if (chk_phase == PH_MIN_END && c == CH_COLON)
                            nx = PH_ES1;
                        else if (chk_phase == PH_FRAC_END && d && ext)
                            nx = PH_FRAC_END;
                        else if (c == CH_Z)
                            nx = PH_DONE;
                        else if (c == CH_PLUS || c == CH_DASH)
                            nx = PH_TZ1;
                        else
                            nx = PH_FIXED;
                    end
                    PH_BF1: nx = d ? PH_BF2 : PH_FIXED;
                    PH_BF2: nx = d ? PH_BF3 : PH_FIXED;
                    PH_BF3: nx = d ? PH_FRAC_END : PH_FIXED;
                    PH_TZ1: nx = d ? PH_TZ2 : PH_FIXED;
                    PH_TZ2: nx = d ? PH_TZ3 : PH_FIXED;
                    PH_TZ3: nx = (ext ? (c == CH_COLON) : d) ? PH_TZ4 : PH_FIXED;
                    PH_TZ4: nx = d ? (ext ? PH_TZ5 : PH_DONE) : PH_FIXED;
                    PH_TZ5: nx = d ? PH_DONE : PH_FIXED;
                    PH_ES1, PH_ES2: begin
                        if (!d) begin
                            nx = PH_FIXED;
                        end else begin
                            chk_sec = next7(chk_sec, c);
                            nx = (chk_phase == PH_ES1) ? PH_ES2 : PH_SEC_END;
                        end
                    end
                    default: nx = PH_FIXED;
                endcase
                if (nx == PH_FIXED) begin
                    chk_basic = 1'b0;
                    chk_ext   = 1'b0;
                end
                chk_phase = nx;
            end
        end
        if (chk_pos != POS_MAX)
            chk_pos = chk_pos + 1'b1;
        if (fin) begin
            acc = (chk_basic || chk_ext) &&
                  (chk_phase == PH_SEC_END || chk_phase == PH_FRAC_END ||
                   chk_phase == PH_DONE || chk_phase == PH_MIN_END) &&
                  date_in_range() && chk_hour <= 23 && chk_min <= 59 && chk_sec <= 59;
            v.valid_res = acc;
            v.form      = !acc ? FORM_NONE : (chk_basic ? FORM_BASIC : FORM_EXTENDED);
            verdicts_due.push_back(v);
            clear_string_state();
        end
    endtask

    // ---------------- stimulus construction ----------------

    task automatic put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            text_buf.push_back(s[i]);
    endtask

    task automatic put_digits(input int n);
        for (int i = 0; i < n; i++)
            text_buf.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
    endtask

    task automatic put_sign();
        text_buf.push_back($urandom_range(0, 1) ? CH_PLUS : CH_DASH);
    endtask

    // Move the text buffer to the pending items as one string.
    task automatic emit_buf(input bit drain);
        char_item_t it;
        for (int i = 0; i < text_buf.size(); i++) begin
            it.ch             = text_buf[i];
            it.last           = (i == text_buf.size() - 1);
            it.hold_for_drain = drain && (i == 0);
            chars_pending.push_back(it);
        end
        text_buf.delete();
    endtask

    task automatic emit_str(input string s);
        put_str(s);
        emit_buf(1'b0);
    endtask

    function automatic int pick(input int lo, input int hi, input int wild_hi);
        return ($urandom_range(0, 7) == 0) ? $urandom_range(0, wild_hi) : $urandom_range(lo, hi);
    endfunction

    // Fill the text buffer with a datetime of correct shape and random content.
    task automatic gen_datetime();
        int y, mo, dd, hh, mi, ss;
        case ($urandom_range(0, 5))
            0:       y = 2000;
            1:       y = 1900;
            2:       y = 2024;
            3:       y = 2023;
            default: y = $urandom_range(0, 9999);
        endcase
        mo = pick(1, 12, 99);
        case ($urandom_range(0, 9))
            0:       dd = 0;
            1:       dd = 29;
            2:       dd = 30;
            3:       dd = 31;
            4:       dd = 32;
            default: dd = $urandom_range(1, 28);
        endcase
        hh = pick(0, 23, 99);
        mi = pick(0, 59, 99);
        ss = pick(0, 59, 99);
        if ($urandom_range(0, 1)) begin
            put_str($sformatf("%04d%02d%02dT%02d%02d%02d", y, mo, dd, hh, mi, ss));
            if ($urandom_range(0, 1)) begin
                text_buf.push_back(CH_DOT);
                put_digits(3);
            end
            case ($urandom_range(0, 2))
                0: ;
                1: text_buf.push_back(CH_Z);
                default: begin
                    put_sign();
                    put_digits(4);
                end
            endcase
        end else begin
            put_str($sformatf("%04d-%02d-%02dT%02d:%02d", y, mo, dd, hh, mi));
            if ($urandom_range(0, 1)) begin
                put_str($sformatf(":%02d", ss));
                if ($urandom_range(0, 1)) begin
                    text_buf.push_back(CH_DOT);
                    put_digits(($urandom_range(0, 9) == 0) ? $urandom_range(25, 40)
                                                           : $urandom_range(0, 6));
                end
            end
            case ($urandom_range(0, 2))
                0: ;
                1: text_buf.push_back(CH_Z);
                default: begin
                    put_sign();
                    put_digits(2);
                    text_buf.push_back(CH_COLON);
                    put_digits(2);
                end
            endcase
        end
    endtask

    task automatic build_directed();
        emit_str("20240229T235959");
        emit_str("20230229T120000");
        emit_str("19000229T000000");
        emit_str("20000229T000000");
        emit_str("00000229T000000");
        emit_str("99991231T235959");
        emit_str("2024-02-29T23:59");
        emit_str("2024-12-31T23:59:59.123456Z");
        emit_str("2024-01-01T00:00:00.+05:30");
        emit_str("20240101T000000.123Z");
        emit_str("20240101T000000.12Z");
        emit_str("20240101T000000-9999");
        emit_str("2024-01-01T00:00-05:30");
        emit_str("20241301T000000");
        emit_str("20240100T000000");
        emit_str("2024-04-31T10:10");
        emit_str("20240101T240000");
        emit_str("20240101T006000");
        emit_str("2024-01-01T00:00:60");
        emit_str("2024-01-01");
        emit_str("Z");
        emit_str("2024-01-01T00:00:00ZX");
        // NUL is an ordinary, rejected character
        put_str("2024-01-01T00:00");
        text_buf.push_back(8'h00);
        emit_buf(1'b0);
        text_buf.push_back(8'h00);
        emit_buf(1'b0);
        // fraction long enough to saturate the position counter
        put_str("2024-01-01T00:00:00.");
        put_digits(40);
        text_buf.push_back(CH_Z);
        emit_buf(1'b0);
        for (int i = 0; i < 16; i++)
            text_buf.push_back(8'hFF);
        emit_buf(1'b0);
    endtask

    task automatic build_random();
        int start_len;
        int r;
        int idx;
        int n;
        bit first;
        start_len = chars_pending.size();
        first = 1'b1;
        while (chars_pending.size() - start_len < RANDOM_CHARS) begin
            r = $urandom_range(0, 99);
            gen_datetime();
            if (r < 70) begin
                // keep the well-formed string
            end else if (r < 80) begin
                idx = $urandom_range(0, text_buf.size() - 1);
                text_buf[idx] = 8'($urandom_range(0, 255));
            end else if (r < 88) begin
                n = $urandom_range(1, text_buf.size());
                while (text_buf.size() > n)
                    void'(text_buf.pop_back());
                if ($urandom_range(0, 1))
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end else begin
                text_buf.delete();
                n = $urandom_range(1, 24);
                for (int i = 0; i < n; i++)
                    text_buf.push_back(8'($urandom_range(0, 255)));
            end
            emit_buf(first || $urandom_range(0, 19) == 0);
            first = 1'b0;
        end
    endtask

    function automatic bit quiet_window();
        return sent_count >= QUIET_FROM && sent_count < QUIET_TO;
    endfunction

    // ---------------- driver ----------------

    always @(posedge aclk) begin : feed_proc
        char_item_t nxt;
        bit         busy;
        busy = s_tvalid;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                advance_checker_model(s_tdata, s_tlast);
                sent_count <= sent_count + 1;
                busy = 1'b0;
            end
            if (!busy) begin
                if (chars_pending.size() != 0 &&
                    !(chars_pending[0].hold_for_drain && verdicts_due.size() != 0) &&
                    (quiet_window() || $urandom_range(0, 99) >= IDLE_PERCENT)) begin
                    nxt = chars_pending.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= nxt.ch;
                    s_tlast  <= nxt.last;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // ---------------- receiver ----------------

    always @(posedge aclk) begin : sink_proc
        int stall_left;
        bit stall_done;
        if (!aresetn) begin
            m_tready   <= 1'b0;
            stall_left = 0;
            stall_done = 1'b0;
        end else if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left = stall_left - 1;
        end else if (!stall_done && sent_count >= STALL_AT) begin
            // hold off long enough for the block to back up into its input
            m_tready   <= 1'b0;
            stall_left = STALL_CYCLES;
            stall_done = 1'b1;
        end else begin
            m_tready <= quiet_window() || $urandom_range(0, 99) >= IDLE_PERCENT;
        end
    end

    always @(posedge aclk) begin : watch_proc
        verdict_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (verdicts_due.size() == 0) begin
                report_mismatch($sformatf("result %h with no string pending", m_tdata));
            end else begin
                want = verdicts_due.pop_front();
                if (m_tdata[0] !== want.valid_res)
                    report_mismatch($sformatf("valid_res %b, want %b",
                                              m_tdata[0], want.valid_res));
                if (m_tdata[2:1] !== want.form)
                    report_mismatch($sformatf("form %0d, want %0d", m_tdata[2:1], want.form));
                if (m_tdata[7:3] !== 5'b0)
                    report_mismatch($sformatf("padding bits %b not zero", m_tdata[7:3]));
            end
        end
    end

    // ---------------- sequencing ----------------

    initial begin
        clear_string_state();
        build_directed();
        build_random();
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        while (chars_pending.size() != 0 || s_tvalid || verdicts_due.size() != 0)
            @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (verdicts_due.size() != 0)
            report_mismatch($sformatf("%0d verdicts never arrived", verdicts_due.size()));
        if (err_count == 0) begin
            $display("iso8601_datetime_checker_core regression: pass");
        end else begin
            $display("iso8601_datetime_checker_core regression: fail");
        end
        $finish;
    end

    initial begin
        #(2 * CLK_HALF * LIMIT_CYCLES);
        $display("timeout after %0d cycles", LIMIT_CYCLES);
        $display("iso8601_datetime_checker_core regression: fail");
        $finish;
    end

endmodule

// File: files.f
sv/iso_dtc_pkg.sv
sv/iso_dtc_step.sv
sv/iso8601_datetime_checker_core.sv
tb/sv/tb_top.sv
